// File: rtl/sls_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list store package
// Command and result word layouts, command and status codes, cell control.
// ----------------------------------------------------------------------------
package sls_pkg;

    localparam int VALUE_W  = 16;
    localparam int REPORT_W = 6;

    // Command codes carried in the command field.
    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_POP    = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    // Status codes returned with every result word.
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]                command;
        logic signed [VALUE_W-1:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [REPORT_W-1:0]       entry_count;
        logic signed [VALUE_W-1:0] head_value;
        logic                      head_valid;
        logic [REPORT_W-1:0]       removed_count;
    } rsp_word_t;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_INSERT,
        CELL_POP,
        CELL_REMOVE,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [VALUE_W-1:0] operand;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_REMOVE
    } state_t;

endpackage

// File: rtl/sls_stream_if.sv
// ----------------------------------------------------------------------------
// Sorted list store stream channel
// Valid/ready channel that carries one word of a given payload type.
// ----------------------------------------------------------------------------
interface sls_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sorted_list_store.sv
// ----------------------------------------------------------------------------
// Sorted list store
// Ordered store of signed 16-bit values built as a chain of cells.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Word        Contents
//   cmd      in   cmd_word_t  command, value
//   rsp      out  rsp_word_t  status, entry_count, head_value, head_valid,
//                             removed_count
//
// Push, sorted insert, pop, clear and unused codes finish in the cycle the
// command word is accepted; the result word is registered at that edge.
// Remove-all-equal deletes one matching element per cycle through the chain,
// and its result word is registered once no matching element is left.
// Reset empties the store at once; stored values need no clearing.
// A stalled result word holds in the output register and blocks new commands.
//
module sorted_list_store #(
    parameter int CAPACITY = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    sls_stream_if.sink   cmd,
    sls_stream_if.source rsp
);
    import sls_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Cell chain wiring. Position 0 is the front of the list.
    logic signed [VALUE_W-1:0] cell_value      [CAPACITY];
    logic                      cell_valid      [CAPACITY];
    logic signed [VALUE_W-1:0] cell_value_next [CAPACITY];
    logic                      cell_valid_next [CAPACITY];
    logic                      seen            [CAPACITY+1];

    cell_ctrl_t ctrl;

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W-1:0]          removed_reg;
    logic [CNT_W-1:0]          removed_next;
    logic signed [VALUE_W-1:0] operand_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    rsp_word_t                 out_data_reg;
    rsp_word_t                 out_data_next;

    logic       accept;
    logic       full;
    logic       empty;
    logic       any_match;
    logic       out_load;
    logic [1:0] status;

    logic [CNT_W+REPORT_W-1:0] count_wide;
    logic [CNT_W+REPORT_W-1:0] removed_wide;

    assign seen[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [VALUE_W-1:0] left_value;
            logic                      left_valid;
            logic signed [VALUE_W-1:0] right_value;
            logic                      right_valid;

            // The front cell is fed the operand from the left; the last cell
            // sees an empty position on its right.
            if (gi == 0)
            begin : g_front
                assign left_value = ctrl.operand;
                assign left_valid = 1'b1;
            end
            else
            begin : g_inner_left
                assign left_value = cell_value[gi-1];
                assign left_valid = cell_valid[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_back
                assign right_value = '0;
                assign right_valid = 1'b0;
            end
            else
            begin : g_inner_right
                assign right_value = cell_value[gi+1];
                assign right_valid = cell_valid[gi+1];
            end

            sls_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_value  (left_value),
                .left_valid  (left_valid),
                .right_value (right_value),
                .right_valid (right_valid),
                .seen_in     (seen[gi]),
                .seen_out    (seen[gi+1]),
                .value       (cell_value[gi]),
                .valid       (cell_valid[gi]),
                .value_next  (cell_value_next[gi]),
                .valid_next  (cell_valid_next[gi])
            );
        end
    endgenerate

    // A new command is taken only while idle and with room in the output
    // register, either empty or being drained in this cycle.
    assign cmd.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = cmd.valid && cmd.ready;

    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign any_match = seen[CAPACITY];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.data.command == CMD_REMOVE))
                    state_next = ST_REMOVE;
            end
            ST_REMOVE:
            begin
                if (!any_match)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control. While idle the operand comes straight from the
    // command word; during a removal it comes from the held copy.
    always_comb
    begin
        ctrl.op      = CELL_HOLD;
        ctrl.operand = operand_reg;
        count_next   = count_reg;
        removed_next = removed_reg;
        status       = STATUS_DONE;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.operand = cmd.data.value;
                if (accept)
                begin
                    removed_next = '0;
                    out_load     = 1'b1;
                    case (cmd.data.command)
                        CMD_PUSH, CMD_INSERT:
                        begin
                            if (full)
                            begin
                                status = STATUS_FULL;
                            end
                            else
                            begin
                                ctrl.op    = (cmd.data.command == CMD_PUSH) ?
                                             CELL_PUSH : CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (empty)
                            begin
                                status = STATUS_EMPTY;
                            end
                            else
                            begin
                                ctrl.op      = CELL_POP;
                                count_next   = count_reg - CNT_W'(1);
                                removed_next = CNT_W'(1);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            out_load = 1'b0;
                        end
                        CMD_CLEAR:
                        begin
                            ctrl.op      = CELL_CLEAR;
                            count_next   = '0;
                            removed_next = count_reg;
                        end
                        default:
                        begin
                            ctrl.op = CELL_HOLD;
                        end
                    endcase
                end
            end
            ST_REMOVE:
            begin
                // Each cycle drops the first matching element; the chain's
                // carry shows whether any match is left.
                ctrl.op = CELL_REMOVE;
                if (any_match)
                begin
                    count_next   = count_reg - CNT_W'(1);
                    removed_next = removed_reg + CNT_W'(1);
                end
                else
                begin
                    out_load = 1'b1;
                end
            end
            default:
            begin
                ctrl.op = CELL_HOLD;
            end
        endcase
    end

    // Result word built from the store as it stands after this command.
    assign count_wide   = {{REPORT_W{1'b0}}, count_next};
    assign removed_wide = {{REPORT_W{1'b0}}, removed_next};

    always_comb
    begin
        out_data_next.status        = status;
        out_data_next.entry_count   = count_wide[REPORT_W-1:0];
        out_data_next.head_valid    = cell_valid_next[0];
        out_data_next.head_value    = cell_valid_next[0] ? cell_value_next[0] : '0;
        out_data_next.removed_count = removed_wide[REPORT_W-1:0];
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            removed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            removed_reg   <= removed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            operand_reg <= cmd.data.value;
        if (out_load)
            out_data_reg <= out_data_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

// File: rtl/sls_cell.sv
// ----------------------------------------------------------------------------
// Sorted list store cell
// One position of the list: a value, its occupied flag, and neighbor moves.
// ----------------------------------------------------------------------------
module sls_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sls_pkg::cell_ctrl_t              ctrl,
    input  logic signed [sls_pkg::VALUE_W-1:0] left_value,
    input  logic                             left_valid,
    input  logic signed [sls_pkg::VALUE_W-1:0] right_value,
    input  logic                             right_valid,
    input  logic                             seen_in,
    output logic                             seen_out,
    output logic signed [sls_pkg::VALUE_W-1:0] value,
    output logic                             valid,
    output logic signed [sls_pkg::VALUE_W-1:0] value_next,
    output logic                             valid_next
);
    import sls_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic                      valid_reg;
    logic                      hit;

    // A cell hits where an insert stops or where a remove finds a match.
    always_comb
    begin
        case (ctrl.op)
            CELL_INSERT: hit = !valid_reg || (ctrl.operand <= value_reg);
            CELL_REMOVE: hit = valid_reg && (ctrl.operand == value_reg);
            default:     hit = 1'b0;
        endcase
    end

    assign seen_out = seen_in || hit;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            CELL_PUSH:
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
            CELL_INSERT:
            begin
                if (seen_in)
                begin
                    value_next = left_value;
                    valid_next = left_valid;
                end
                else if (hit)
                begin
                    value_next = ctrl.operand;
                    valid_next = 1'b1;
                end
            end
            CELL_POP:
            begin
                value_next = right_value;
                valid_next = right_valid;
            end
            CELL_REMOVE:
            begin
                if (seen_out)
                begin
                    value_next = right_value;
                    valid_next = right_valid;
                end
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                value_next = value_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// File: rtl/sls_checker.sv
// ----------------------------------------------------------------------------
// Sorted list store checker
// Port-level assertions on the command and result channels.
// ----------------------------------------------------------------------------
module sls_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cmd_valid,
    input logic                               cmd_ready,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic [1:0]                         rsp_status,
    input logic [sls_pkg::REPORT_W-1:0]       rsp_entry_count,
    input logic signed [sls_pkg::VALUE_W-1:0] rsp_head_value,
    input logic                               rsp_head_valid,
    input logic [sls_pkg::REPORT_W-1:0]       rsp_removed_count
);
    import sls_pkg::*;

    // A command is never taken while a result word waits without draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |-> (!rsp_valid || rsp_ready))
        else $error("command accepted over a stalled result word");

    // An empty store reports a zero head value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_head_valid) |-> (rsp_head_value == '0))
        else $error("head value not zero on an empty store");

    // Rejected commands remove nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status != STATUS_DONE)) |-> (rsp_removed_count == '0))
        else $error("rejected command reports removed elements");

    // A pop on an empty store leaves it empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == STATUS_EMPTY)) |->
            (!rsp_head_valid && (rsp_entry_count == '0)))
        else $error("empty pop reports a non-empty store");

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_status) && $stable(rsp_entry_count)
             && $stable(rsp_head_value) && $stable(rsp_removed_count)))
        else $error("result word changed while stalled");

endmodule

bind sorted_list_store sls_checker u_sls_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.data.status),
    .rsp_entry_count   (rsp.data.entry_count),
    .rsp_head_value    (rsp.data.head_value),
    .rsp_head_valid    (rsp.data.head_valid),
    .rsp_removed_count (rsp.data.removed_count)
);
